@@ rtl/core/sot_pkg.sv @@
// Shared types, codes and microprogram of the segment occlusion test.
package sot_pkg;

  localparam int PcW = 5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_START_Z  = 3'd2,
    REG_END_X    = 3'd3,
    REG_END_Y    = 3'd4,
    REG_END_Z    = 3'd5,
    REG_RADIUS   = 3'd6
  } reg_idx_e;

  localparam logic [15:0] RadiusReset = 16'd1024;

  // Multiplier operand sources.
  typedef enum logic [3:0] {
    OP_ZERO,
    OP_AB_X,
    OP_AB_Y,
    OP_AB_Z,
    OP_AP_X,
    OP_AP_Y,
    OP_AP_Z,
    OP_RAD,
    OP_B_LO,
    OP_B_HI,
    OP_T_LO,
    OP_T_HI,
    OP_E_LO,
    OP_E_HI
  } opnd_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Limb shift applied to the product before it reaches the accumulator.
  typedef enum logic [1:0] {
    SH_0,
    SH_1,
    SH_2
  } shift_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_AB2,
    DST_DOT,
    DST_EXC
  } dst_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_PASS,
    COND_ACC_LE0,
    COND_ACC_LT0,
    COND_DOT_GE_AB2
  } cond_e;

  typedef struct packed {
    opnd_e            a_sel;
    opnd_e            b_sel;
    acc_op_e          acc_op;
    shift_e           shift;
    dst_e             dst;
    cond_e            cond;
    logic [PcW-1:0]   target;
    logic             set_hit;
    logic             done;
  } uword_t;

  typedef struct packed {
    logic   active;
    uword_t uw;
  } ctrl_t;

  typedef struct packed {
    logic pass;
    logic acc_le0;
    logic acc_lt0;
    logic dot_ge_ab2;
  } stat_t;

  localparam logic [PcW-1:0] STEP_FIRST = 5'd0;
  localparam logic [PcW-1:0] STEP_HIT   = 5'd20;
  localparam logic [PcW-1:0] STEP_END   = 5'd21;

  localparam uword_t UW_IDLE = '{
    a_sel:   OP_ZERO,
    b_sel:   OP_ZERO,
    acc_op:  ACC_NONE,
    shift:   SH_0,
    dst:     DST_NONE,
    cond:    COND_NONE,
    target:  STEP_END,
    set_hit: 1'b0,
    done:    1'b0
  };

  // Microprogram. The accumulator field of a step consumes the product
  // issued by the step before it; dst stores the accumulator as it stands
  // at the start of the step, and the accumulator conditions look at the same value.
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t uw;
    uw = UW_IDLE;
    unique case (pc)
      5'd0: begin
        uw.a_sel = OP_AB_X; uw.b_sel = OP_AB_X;
        uw.cond = COND_PASS; uw.target = STEP_END;
      end
      5'd1: begin
        uw.a_sel = OP_AB_Y; uw.b_sel = OP_AB_Y; uw.acc_op = ACC_LOAD;
      end
      5'd2: begin
        uw.a_sel = OP_AB_Z; uw.b_sel = OP_AB_Z; uw.acc_op = ACC_ADD;
      end
      5'd3: begin
        uw.a_sel = OP_AP_X; uw.b_sel = OP_AB_X; uw.acc_op = ACC_ADD;
      end
      5'd4: begin
        uw.a_sel = OP_AP_Y; uw.b_sel = OP_AB_Y; uw.acc_op = ACC_LOAD;
        uw.dst = DST_AB2;
      end
      5'd5: begin
        uw.a_sel = OP_AP_Z; uw.b_sel = OP_AB_Z; uw.acc_op = ACC_ADD;
      end
      5'd6: begin
        uw.a_sel = OP_AP_X; uw.b_sel = OP_AP_X; uw.acc_op = ACC_ADD;
      end
      5'd7: begin
        // projection must land past the start point
        uw.a_sel = OP_AP_Y; uw.b_sel = OP_AP_Y; uw.acc_op = ACC_LOAD;
        uw.dst = DST_DOT; uw.cond = COND_ACC_LE0; uw.target = STEP_END;
      end
      5'd8: begin
        // ... and short of the end point
        uw.a_sel = OP_AP_Z; uw.b_sel = OP_AP_Z; uw.acc_op = ACC_ADD;
        uw.cond = COND_DOT_GE_AB2; uw.target = STEP_END;
      end
      5'd9: begin
        uw.a_sel = OP_RAD; uw.b_sel = OP_RAD; uw.acc_op = ACC_ADD;
      end
      5'd10: begin
        uw.a_sel = OP_T_LO; uw.b_sel = OP_T_LO; uw.acc_op = ACC_SUB;
      end
      5'd11: begin
        // |ap|^2 - r^2 <= 0 always blocks
        uw.a_sel = OP_T_LO; uw.b_sel = OP_T_HI; uw.acc_op = ACC_LOAD;
        uw.dst = DST_EXC; uw.cond = COND_ACC_LE0; uw.target = STEP_HIT;
      end
      5'd12: begin
        uw.a_sel = OP_T_HI; uw.b_sel = OP_T_LO; uw.acc_op = ACC_ADD;
        uw.shift = SH_1;
      end
      5'd13: begin
        uw.a_sel = OP_T_HI; uw.b_sel = OP_T_HI; uw.acc_op = ACC_ADD;
        uw.shift = SH_1;
      end
      5'd14: begin
        uw.a_sel = OP_E_LO; uw.b_sel = OP_B_LO; uw.acc_op = ACC_ADD;
        uw.shift = SH_2;
      end
      5'd15: begin
        uw.a_sel = OP_E_LO; uw.b_sel = OP_B_HI; uw.acc_op = ACC_SUB;
      end
      5'd16: begin
        uw.a_sel = OP_E_HI; uw.b_sel = OP_B_LO; uw.acc_op = ACC_SUB;
        uw.shift = SH_1;
      end
      5'd17: begin
        uw.a_sel = OP_E_HI; uw.b_sel = OP_B_HI; uw.acc_op = ACC_SUB;
        uw.shift = SH_1;
      end
      5'd18: begin
        uw.acc_op = ACC_SUB; uw.shift = SH_2;
      end
      5'd19: begin
        // dot^2 - (|ap|^2 - r^2) * ab2 < 0 means clear of the segment
        uw.cond = COND_ACC_LT0; uw.target = STEP_END;
      end
      5'd20: begin
        uw.set_hit = 1'b1;
      end
      5'd21: begin
        uw.done = 1'b1;
      end
      default: begin
        uw.done = 1'b1;
      end
    endcase
    return uw;
  endfunction

endpackage

@@ rtl/core/sot_sequencer.sv @@
// Step counter and branch logic that walks the occlusion microprogram.
module sot_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           end_hold_i,
  input  sot_pkg::stat_t stat_i,
  output logic           busy_o,
  output sot_pkg::ctrl_t ctrl_o
);
  import sot_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw;
  logic           taken;

  assign uw = ucode(pc_q);

  always_comb begin
    unique case (uw.cond)
      COND_NONE:       taken = 1'b0;
      COND_PASS:       taken = stat_i.pass;
      COND_ACC_LE0:    taken = stat_i.acc_le0;
      COND_ACC_LT0:    taken = stat_i.acc_lt0;
      COND_DOT_GE_AB2: taken = stat_i.dot_ge_ab2;
      default:         taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        pc_d   = STEP_FIRST;
      end
    end else if (uw.done) begin
      // last step of a last point waits while the result register is still occupied
      if (!end_hold_i) begin
        busy_d = 1'b0;
      end
    end else if (taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= STEP_FIRST;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o        = busy_q;
  assign ctrl_o.active = busy_q;
  assign ctrl_o.uw     = uw;

endmodule

@@ rtl/core/sot_datapath.sv @@
// Shared multiplier, wide accumulator and operand registers of the occlusion test.
module sot_datapath #(
  parameter int CB = 20
) (
  input  logic                   clk_i,
  input  logic [2:0][CB-1:0]     pt_i,
  input  logic [2:0][CB-1:0]     start_i,
  input  logic [2:0][CB-1:0]     end_i,
  input  logic [15:0]            radius_i,
  input  logic                   pass_i,
  input  sot_pkg::ctrl_t         ctrl_i,
  output sot_pkg::stat_t         stat_o
);
  import sot_pkg::*;

  // limb width: holds a coordinate difference with headroom and the radius
  localparam int W  = (CB + 2 > 17) ? CB + 2 : 17;
  localparam int PW = 2 * W;
  localparam int AW = 4 * W + 2;

  logic [5:0][CB-1:0] minu, subt;
  logic [5:0][CB-1:0] mag;
  logic [5:0]         sgn;

  logic [W-1:0] op_mag [2];
  logic         op_sgn [2];

  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] term_raw, term;
  logic [PW-1:0] b_q, t_q, e_q;

  // differences: ab = end - start (0..2), ap = point - start (3..5)
  assign minu[2:0] = end_i;
  assign minu[5:3] = pt_i;
  assign subt[2:0] = start_i;
  assign subt[5:3] = start_i;

  for (genvar i = 0; i < 6; i++) begin : g_diff
    logic [CB:0] dif, neg;
    assign dif    = {minu[i][CB-1], minu[i]} - {subt[i][CB-1], subt[i]};
    assign neg    = ~dif + (CB+1)'(1);
    assign sgn[i] = dif[CB];
    // |difference| never exceeds 2^CB - 1
    assign mag[i] = sgn[i] ? neg[CB-1:0] : dif[CB-1:0];
  end

  for (genvar p = 0; p < 2; p++) begin : g_opnd
    opnd_e sel;
    assign sel = (p == 0) ? ctrl_i.uw.a_sel : ctrl_i.uw.b_sel;
    always_comb begin
      op_sgn[p] = 1'b0;
      unique case (sel)
        OP_ZERO: op_mag[p] = '0;
        OP_AB_X: begin op_mag[p] = W'(mag[0]); op_sgn[p] = sgn[0]; end
        OP_AB_Y: begin op_mag[p] = W'(mag[1]); op_sgn[p] = sgn[1]; end
        OP_AB_Z: begin op_mag[p] = W'(mag[2]); op_sgn[p] = sgn[2]; end
        OP_AP_X: begin op_mag[p] = W'(mag[3]); op_sgn[p] = sgn[3]; end
        OP_AP_Y: begin op_mag[p] = W'(mag[4]); op_sgn[p] = sgn[4]; end
        OP_AP_Z: begin op_mag[p] = W'(mag[5]); op_sgn[p] = sgn[5]; end
        OP_RAD:  op_mag[p] = W'(radius_i);
        OP_B_LO: op_mag[p] = b_q[W-1:0];
        OP_B_HI: op_mag[p] = b_q[PW-1:W];
        OP_T_LO: op_mag[p] = t_q[W-1:0];
        OP_T_HI: op_mag[p] = t_q[PW-1:W];
        OP_E_LO: op_mag[p] = e_q[W-1:0];
        OP_E_HI: op_mag[p] = e_q[PW-1:W];
        default: op_mag[p] = '0;
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.uw.shift)
      SH_0:    term_raw = AW'(prod_q);
      SH_1:    term_raw = AW'(prod_q) << W;
      SH_2:    term_raw = AW'(prod_q) << PW;
      default: term_raw = '0;
    endcase
    term = neg_q ? (~term_raw + AW'(1)) : term_raw;
  end

  always_comb begin
    case (ctrl_i.uw.acc_op)
      ACC_LOAD: acc_d = term;
      ACC_ADD:  acc_d = acc_q + term;
      ACC_SUB:  acc_d = acc_q - term;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.active) begin
      prod_q <= op_mag[0] * op_mag[1];
      neg_q  <= op_sgn[0] ^ op_sgn[1];
      acc_q  <= acc_d;
      case (ctrl_i.uw.dst)
        DST_AB2: b_q <= acc_q[PW-1:0];
        DST_DOT: t_q <= acc_q[PW-1:0];
        DST_EXC: e_q <= acc_q[PW-1:0];
        default: ;
      endcase
    end
  end

  assign stat_o.pass       = pass_i;
  assign stat_o.acc_lt0    = acc_q[AW-1];
  assign stat_o.acc_le0    = acc_q[AW-1] || (acc_q == '0);
  assign stat_o.dot_ge_ab2 = (t_q >= b_q);

endmodule

@@ rtl/core/segment_occlusion_test.sv @@
// Top level of the segment occlusion test: registers, point capture, result word.
//
// Tests a stream of 3D points against a segment held in registers 0..5
// (start and end, signed) and a clearance radius in register 6. Config
// writes go over cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, an index beyond the radius is dropped.
// Points arrive on in_valid_i/in_stall_o with skip and last flags. A point
// that is not skipped and projects strictly inside the segment within the
// radius sets a sticky hit flag. After a last point one result word
// (occluded, zero_length) goes out on out_valid_o/out_stall_i and the flag
// clears. One point is in work at a time. A skipped point or a
// zero-length segment ends at the first step, a projection that falls
// outside ends at the dot or bound check, a point inside the radius
// sphere jumps to the hit step, and the full test ends clear or in a hit.
// The 22-step microprogram shares one multiplier. When the receiver
// stalls the result holds in its register and a following last point
// waits at its final step. Reset clears the sequencer, the hit flag and
// the result valid, zeroes the segment and sets the radius to 1024.
module segment_occlusion_test #(
  parameter int COORD_BITS = 20
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [2:0]                                  cfg_index_i,
  input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] cfg_data_i,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic signed [COORD_BITS-1:0]                pt_x_i,
  input  logic signed [COORD_BITS-1:0]                pt_y_i,
  input  logic signed [COORD_BITS-1:0]                pt_z_i,
  input  logic                                        skip_point_i,
  input  logic                                        last_point_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic                                        occluded_o,
  output logic                                        zero_length_o
);
  import sot_pkg::*;

  logic [2:0][COORD_BITS-1:0] start_q, end_q;
  logic [15:0]                radius_q;
  logic [2:0][COORD_BITS-1:0] pt_q;
  logic                       skip_q, last_q;
  logic                       hit_q;
  logic                       out_valid_q, occluded_q, zero_length_q;

  logic   busy, accept, zero, end_hold, finish;
  ctrl_t  ctrl;
  stat_t  stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;
  assign zero        = (start_q == end_q);

  // a last point may only finish once the result register can take a word
  assign end_hold = last_q && out_valid_q && out_stall_i;
  assign finish   = ctrl.active && ctrl.uw.done && !end_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= '0;
      radius_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_X: start_q[0] <= cfg_data_i[COORD_BITS-1:0];
        REG_START_Y: start_q[1] <= cfg_data_i[COORD_BITS-1:0];
        REG_START_Z: start_q[2] <= cfg_data_i[COORD_BITS-1:0];
        REG_END_X:   end_q[0]   <= cfg_data_i[COORD_BITS-1:0];
        REG_END_Y:   end_q[1]   <= cfg_data_i[COORD_BITS-1:0];
        REG_END_Z:   end_q[2]   <= cfg_data_i[COORD_BITS-1:0];
        REG_RADIUS:  radius_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q[0] <= pt_x_i;
      pt_q[1] <= pt_y_i;
      pt_q[2] <= pt_z_i;
      skip_q  <= skip_point_i;
      last_q  <= last_point_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl.active && ctrl.uw.set_hit) begin
      hit_q <= 1'b1;
    end else if (finish && last_q) begin
      hit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish && last_q) begin
      occluded_q    <= hit_q && !zero;
      zero_length_q <= zero;
    end
  end

  sot_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .end_hold_i (end_hold),
    .stat_i     (stat),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  sot_datapath #(
    .CB (COORD_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .pt_i     (pt_q),
    .start_i  (start_q),
    .end_i    (end_q),
    .radius_i (radius_q),
    .pass_i   (skip_q || zero),
    .ctrl_i   (ctrl),
    .stat_o   (stat)
  );

  assign out_valid_o   = out_valid_q;
  assign occluded_o    = occluded_q;
  assign zero_length_o = zero_length_q;

endmodule
